### design/pfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_pkg
// Shared constants, types and state encodings for the fan face-normal core.
// ----------------------------------------------------------------------------
package pfn_pkg;

  localparam int VERTEX_DEPTH = 4096;
  localparam int COORD_WIDTH  = 16;

  localparam int IDX_W   = 13;                      // vertex_index port width
  localparam int ADDR_W  = $clog2(VERTEX_DEPTH);
  localparam int WORD_W  = 3 * COORD_WIDTH;         // x, y, z in one entry
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int SCALE_W = (CROSS_W > 31) ? CROSS_W : 31;

  localparam int FRAC_BITS = 14;                    // Q1.14 output
  localparam int QUOT_W    = FRAC_BITS + 1;
  localparam int LEN_W     = 32;
  localparam int NUM_W     = 31 + FRAC_BITS + 1;
  localparam int OUT_W     = 16;

  localparam logic [QUOT_W-1:0] UNIT_ONE = QUOT_W'(1 << FRAC_BITS);

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_CORNER = 1'b1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } vec_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_CALC
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_CROSS,
    N_CHECK,
    N_SCALE,
    N_SQSUM,
    N_SQRT,
    N_DIVINIT,
    N_DIV
  } norm_state_t;

endpackage

### design/pfn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### design/pfn_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_norm
// Sequential unit normal of (a - b) x (a - c): cross product, common
// normalizing shift, square root of the squared sum and three divisions.
// ----------------------------------------------------------------------------
module pfn_norm import pfn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  vec_t                    a,
  input  vec_t                    b,
  input  vec_t                    c,
  output logic                    done,
  output logic signed [OUT_W-1:0] nx,
  output logic signed [OUT_W-1:0] ny,
  output logic signed [OUT_W-1:0] nz,
  output logic                    degenerate
);

  norm_state_t state, state_next;
  logic        fin;

  logic signed [DIFF_W-1:0] u [3];
  logic signed [DIFF_W-1:0] v [3];
  logic [SCALE_W-1:0]       s [3];
  logic                     neg [3];
  logic [1:0]               k;
  logic [3:0]               step;
  logic [63:0]              sum, x, r, bitv;
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         rem;
  logic [QUOT_W-1:0]        q, qn;
  logic signed [OUT_W-1:0]  res [3];

  // Datapath helpers
  logic signed [DIFF_W-1:0]  ua, vb, ub, va;
  logic signed [PROD_W-1:0]  p1, p2;
  logic signed [CROSS_W-1:0] crv, cmag;
  logic [SCALE_W-1:0]        m;
  logic [61:0]               sq;
  logic [63:0]               rb;
  logic [NUM_W-1:0]          num;
  logic [LEN_W:0]            rem2;
  logic [QUOT_W-1:0]         qf, qc;
  logic signed [OUT_W-1:0]   sres;

  always_comb begin
    case (k)
      2'd0:    begin ua = u[1]; vb = v[2]; ub = u[2]; va = v[1]; end
      2'd1:    begin ua = u[2]; vb = v[0]; ub = u[0]; va = v[2]; end
      default: begin ua = u[0]; vb = v[1]; ub = u[1]; va = v[0]; end
    endcase
    p1   = ua * vb;
    p2   = ub * va;
    crv  = CROSS_W'(p1) - CROSS_W'(p2);
    cmag = crv[CROSS_W-1] ? -crv : crv;
    m    = s[0] | s[1] | s[2];
    sq   = s[k][30:0] * s[k][30:0];
    rb   = r + bitv;
    num  = {1'b0, s[k][30:0], FRAC_BITS'(0)} + NUM_W'(len[LEN_W-1:1]);
    rem2 = {rem, qn[QUOT_W-1]};
    qf   = {q[QUOT_W-2:0], (rem2 >= {1'b0, len})};
    qc   = (qf > UNIT_ONE) ? UNIT_ONE : qf;
    sres = neg[k] ? -OUT_W'(qc) : OUT_W'(qc);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      N_IDLE:    if (start) state_next = N_CROSS;
      N_CROSS:   if (k == 2'd2) state_next = N_CHECK;
      N_CHECK:   state_next = (m == '0) ? N_IDLE : N_SCALE;
      N_SCALE:   if ((m >> 31) == '0 && m[30]) state_next = N_SQSUM;
      N_SQSUM:   if (k == 2'd2) state_next = N_SQRT;
      N_SQRT:    if (bitv == 64'd1) state_next = N_DIVINIT;
      N_DIVINIT: state_next = N_DIV;
      N_DIV:     if (step == 4'(QUOT_W - 1)) state_next = (k == 2'd2) ? N_IDLE : N_DIVINIT;
      default:   state_next = N_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = fin;
    nx   = res[0];
    ny   = res[1];
    nz   = res[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= ((state == N_CHECK) && (m == '0)) ||
               ((state == N_DIV) && (step == 4'(QUOT_W - 1)) && (k == 2'd2));
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        u[0] <= DIFF_W'(a.x) - DIFF_W'(b.x);
        u[1] <= DIFF_W'(a.y) - DIFF_W'(b.y);
        u[2] <= DIFF_W'(a.z) - DIFF_W'(b.z);
        v[0] <= DIFF_W'(a.x) - DIFF_W'(c.x);
        v[1] <= DIFF_W'(a.y) - DIFF_W'(c.y);
        v[2] <= DIFF_W'(a.z) - DIFF_W'(c.z);
        k    <= 2'd0;
      end
      N_CROSS: begin
        s[k]   <= SCALE_W'(unsigned'(cmag));
        neg[k] <= crv[CROSS_W-1];
        k      <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      N_CHECK: begin
        degenerate <= (m == '0);
        if (m == '0) begin
          res[0] <= '0;
          res[1] <= '0;
          res[2] <= '0;
        end
      end
      N_SCALE: begin
        // one common shift toward [2^30, 2^31); right shifts truncate
        if ((m >> 31) != '0) begin
          s[0] <= s[0] >> 1;
          s[1] <= s[1] >> 1;
          s[2] <= s[2] >> 1;
        end else if (!m[30]) begin
          s[0] <= s[0] << 1;
          s[1] <= s[1] << 1;
          s[2] <= s[2] << 1;
        end
        sum <= '0;
        k   <= 2'd0;
      end
      N_SQSUM: begin
        sum <= sum + {2'b00, sq};
        k   <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        x    <= sum + {2'b00, sq};
        r    <= '0;
        bitv <= 64'd1 << 62;
      end
      N_SQRT: begin
        if (x >= rb) begin
          x <= x - rb;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
      end
      N_DIVINIT: begin
        if (bitv == '0 && step == '0 && k == 2'd0) len <= r[LEN_W-1:0];
        rem  <= LEN_W'(num[NUM_W-1:QUOT_W]);
        qn   <= num[QUOT_W-1:0];
        q    <= '0;
        step <= '0;
      end
      N_DIV: begin
        rem  <= (rem2 >= {1'b0, len}) ? LEN_W'(rem2 - {1'b0, len}) : LEN_W'(rem2);
        q    <= qf;
        qn   <= qn << 1;
        if (step == 4'(QUOT_W - 1)) begin
          res[k] <= sres;
          k      <= k + 2'd1;
          step   <= '0;
        end else begin
          step <= step + 4'd1;
        end
      end
      default: ;
    endcase
    if (state == N_SQRT && bitv == 64'd1) begin
      // latch the root as it completes
      len  <= (x >= rb) ? LEN_W'((r >> 1) + bitv) : LEN_W'(r >> 1);
      k    <= 2'd0;
      step <= '0;
    end
  end

endmodule

### design/polygon_fan_face_normals_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_fan_face_normals_core
// Vertex table in a synchronous RAM plus triangle-fan corner tracking; each
// corner from the third on yields the Q1.14 unit normal of its fan triangle.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ---------------    ------------------------------------------
//  in        start / busy       operation, vertex_index, coord_x/y/z,
//                               face_start (beat taken when start & !busy)
//  out       done (1 cycle)     normal_x/y/z, degenerate
//
// A store beat leaves busy low. A corner beat reads the RAM; one that opens
// a fan or gives its second corner raises no done, and busy falls after
// T_READ. A fan triangle runs through the normal unit: cross product,
// zero check, common shift, squared sum, square root and three divisions;
// the shift count sets how long it runs. A degenerate triangle stops after
// the zero check and is done with zero normals and degenerate set.
// Reset (rst, synchronous) clears the corner count; table contents stay
// undefined until written. The receiver cannot stall: done lasts one cycle.
module polygon_fan_face_normals_core import pfn_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [IDX_W-1:0]              vertex_index,
  input  logic signed [15:0]            coord_x,
  input  logic signed [15:0]            coord_y,
  input  logic signed [15:0]            coord_z,
  input  logic                          face_start,
  output logic                          done,
  output logic signed [OUT_W-1:0]       normal_x,
  output logic signed [OUT_W-1:0]       normal_y,
  output logic signed [OUT_W-1:0]       normal_z,
  output logic                          degenerate
);

  top_state_t state, state_next;

  logic              accept, idx_ok;
  logic [IDX_W-1:0]  idx_m1;
  logic              ram_en, ram_we;
  logic [WORD_W-1:0] ram_rdata;
  vec_t              wvec, cur;

  // Corner tracking
  vec_t       first, prev;
  logic [1:0] count;
  logic       fs_hold, ok_hold;
  logic       emit;
  logic       norm_done;

  assign accept = start && !busy;
  assign idx_m1 = vertex_index - IDX_W'(1);
  assign idx_ok = (vertex_index != '0) && (vertex_index <= IDX_W'(VERTEX_DEPTH));

  // Store on a store beat with a valid index; read on a corner beat
  assign ram_en = accept && (operation == OP_STORE ? idx_ok : 1'b1);
  assign ram_we = (operation == OP_STORE);

  always_comb begin
    wvec.x = coord_x[COORD_WIDTH-1:0];
    wvec.y = coord_y[COORD_WIDTH-1:0];
    wvec.z = coord_z[COORD_WIDTH-1:0];
  end

  pfn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (idx_m1[ADDR_W-1:0]),
    .wdata (wvec),
    .rdata (ram_rdata)
  );

  // Out-of-range corners use the origin
  assign cur  = ok_hold ? vec_t'(ram_rdata) : '0;
  assign emit = !fs_hold && (count == 2'd2);

  pfn_norm u_norm (
    .clk        (clk),
    .rst        (rst),
    .start      ((state == T_READ) && emit),
    .a          (first),
    .b          (prev),
    .c          (cur),
    .done       (norm_done),
    .nx         (normal_x),
    .ny         (normal_y),
    .nz         (normal_z),
    .degenerate (degenerate)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (accept && operation == OP_CORNER) state_next = T_READ;
      T_READ:  state_next = emit ? T_CALC : T_IDLE;
      T_CALC:  if (norm_done) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (state != T_IDLE);
    done = norm_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      count <= 2'd0;
    end else begin
      state <= state_next;
      if (state == T_READ) begin
        // open a fan, take the second corner, or advance the fan
        if (fs_hold || count == 2'd0) begin
          count <= 2'd1;
        end else if (count == 2'd1) begin
          count <= 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fs_hold <= face_start;
      ok_hold <= idx_ok;
    end
    if (state == T_READ) begin
      if (fs_hold || count == 2'd0) first <= cur;
      prev <= cur;
    end
  end

endmodule
